// ===== sv/hsi_pkg.sv =====
package hsi_pkg;

	// The table size is a power of two so that the hash and the probe wrap are masks.
	localparam int SLOT_W      = 10;
	localparam int TABLE_SLOTS = 1 << SLOT_W;
	localparam int CHAR_W      = 8;
	localparam int FIELD_W     = 10;
	localparam int ENTRY_W     = CHAR_W + SLOT_W;

	localparam logic [FIELD_W-1:0] LENGTH_MAX = {FIELD_W{1'b1}};

	localparam logic [CHAR_W-1:0] CH_QMARK = 8'h3F;
	localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
	localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	typedef enum logic [1:0] {
		ST_FOLLOW = 2'd0,
		ST_CLAIM  = 2'd1,
		ST_NOSYM  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		FSM_CLEAR = 5'b00001,
		FSM_IDLE  = 5'b00010,
		FSM_HASH  = 5'b00100,
		FSM_CHECK = 5'b01000,
		FSM_DONE  = 5'b10000
	} fsm_t;

	typedef struct packed {
		logic    accept;
		logic    hash;
		logic    advance;
		logic    rd_next;
		logic    claim;
		logic    take;
		logic    clear_step;
		logic    load_out;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic sym_ok;
		logic match;
		logic empty;
		logic wrap;
		logic clr_last;
	} sts_t;

endpackage

// ===== sv/hsi_if.sv =====
interface hsi_in_if;
	logic                        valid;
	logic                        ready;
	logic [hsi_pkg::CHAR_W-1:0]  char_code;
	logic                        start_of_name;

	modport source (output valid, output char_code, output start_of_name, input ready);
	modport sink   (input valid, input char_code, input start_of_name, output ready);
endinterface

interface hsi_out_if;
	logic                        valid;
	logic                        ready;
	logic [hsi_pkg::FIELD_W-1:0] node_index;
	logic [hsi_pkg::FIELD_W-1:0] name_length;
	logic [1:0]                  status;

	modport source (output valid, output node_index, output name_length, output status,
		input ready);
	modport sink   (input valid, input node_index, input name_length, input status,
		output ready);
endinterface

// ===== sv/hsi_ram.sv =====
module hsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/hsi_datapath.sv =====
module hsi_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  hsi_pkg::cmd_t   cmd,
	output hsi_pkg::sts_t   sts,
	hsi_in_if.sink          sym_data,
	hsi_out_if.source       res_data
);

	logic [hsi_pkg::CHAR_W-1:0]   c_q;
	logic [hsi_pkg::SLOT_W-1:0]   cur_q;
	logic [hsi_pkg::FIELD_W-1:0]  len_q;
	logic [hsi_pkg::SLOT_W-1:0]   h_q;
	logic [hsi_pkg::SLOT_W-1:0]   start_q;
	logic [hsi_pkg::SLOT_W-1:0]   clr_q;
	logic [hsi_pkg::FIELD_W-1:0]  node_q;
	logic [hsi_pkg::FIELD_W-1:0]  length_q;
	hsi_pkg::status_t             status_q;

	logic [2*hsi_pkg::CHAR_W-1:0]                 sq;
	logic [2*hsi_pkg::CHAR_W+hsi_pkg::SLOT_W-1:0] sq_ext;
	logic [hsi_pkg::CHAR_W+hsi_pkg::SLOT_W-1:0]   c_ext;
	logic [hsi_pkg::SLOT_W+hsi_pkg::FIELD_W-1:0]  cur_ext;
	logic [hsi_pkg::SLOT_W-1:0]   hash_w;
	logic [hsi_pkg::SLOT_W-1:0]   step_w;
	logic [hsi_pkg::SLOT_W-1:0]   h_next;
	logic [hsi_pkg::CHAR_W-1:0]   r_char;
	logic [hsi_pkg::SLOT_W-1:0]   r_parent;
	logic [hsi_pkg::ENTRY_W-1:0]  rdata;
	logic [hsi_pkg::ENTRY_W-1:0]  wdata;
	logic [hsi_pkg::SLOT_W-1:0]   waddr;
	logic [hsi_pkg::SLOT_W-1:0]   raddr;
	logic                         we;
	logic                         is_letter;
	logic                         is_digit;

	// Reduction modulo the table size is a truncation to the slot index width.
	assign sq      = c_q * c_q;
	assign sq_ext  = {{hsi_pkg::SLOT_W{1'b0}}, sq};
	assign c_ext   = {{hsi_pkg::SLOT_W{1'b0}}, c_q};
	assign cur_ext = {{hsi_pkg::FIELD_W{1'b0}}, cur_q};
	assign hash_w  = cur_q + sq_ext[hsi_pkg::SLOT_W-1:0];
	assign step_w  = c_ext[hsi_pkg::SLOT_W-1:0];
	assign h_next  = h_q + step_w;

	assign is_letter = (c_q >= hsi_pkg::CH_UP_A && c_q <= hsi_pkg::CH_UP_Z) ||
		(c_q >= hsi_pkg::CH_LO_A && c_q <= hsi_pkg::CH_LO_Z) ||
		c_q == hsi_pkg::CH_UNDER || c_q == hsi_pkg::CH_DOT;
	assign is_digit  = c_q >= hsi_pkg::CH_ZERO && c_q <= hsi_pkg::CH_NINE;

	assign r_char   = rdata[hsi_pkg::ENTRY_W-1 -: hsi_pkg::CHAR_W];
	assign r_parent = rdata[hsi_pkg::SLOT_W-1:0];

	assign sts.sym_ok   = is_letter || (is_digit && len_q != '0);
	assign sts.match    = r_char == c_q && r_parent == cur_q;
	assign sts.empty    = r_char == hsi_pkg::CH_NUL;
	assign sts.wrap     = h_next == start_q;
	assign sts.clr_last = clr_q == {hsi_pkg::SLOT_W{1'b1}};

	// The clearing sweep owns the write port after reset; slot 0 gets the reserved mark.
	always_comb begin
		we    = cmd.clear_step || cmd.claim;
		waddr = h_q;
		wdata = {c_q, cur_q};
		if (cmd.clear_step) begin
			waddr = clr_q;
			wdata = (clr_q == '0) ? {hsi_pkg::CH_QMARK, {hsi_pkg::SLOT_W{1'b0}}} : '0;
		end
	end

	assign raddr = cmd.rd_next ? h_next : hash_w;

	hsi_ram #(
		.WIDTH (hsi_pkg::ENTRY_W),
		.DEPTH (hsi_pkg::TABLE_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			len_q <= '0;
			clr_q <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept && sym_data.start_of_name) begin
				cur_q <= '0;
				len_q <= '0;
			end
			if (cmd.take) begin
				cur_q <= h_q;
				if (len_q != hsi_pkg::LENGTH_MAX) begin
					len_q <= len_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			c_q <= sym_data.char_code;
		end
		if (cmd.hash) begin
			h_q     <= hash_w;
			start_q <= hash_w;
		end else if (cmd.advance) begin
			h_q <= h_next;
		end
		if (cmd.load_out) begin
			node_q   <= cur_ext[hsi_pkg::FIELD_W-1:0];
			length_q <= len_q;
			status_q <= cmd.out_status;
		end
	end

	assign res_data.node_index  = node_q;
	assign res_data.name_length = length_q;
	assign res_data.status      = status_q;

endmodule

// ===== sv/hsi_ctrl.sv =====
module hsi_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  hsi_pkg::sts_t sts,
	output hsi_pkg::cmd_t cmd
);

	hsi_pkg::fsm_t    state_q;
	hsi_pkg::fsm_t    state_d;
	hsi_pkg::status_t status_q;
	hsi_pkg::status_t status_d;
	logic             out_valid_q;
	logic             out_free;

	assign in_ready  = state_q == hsi_pkg::FSM_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d        = state_q;
		status_d       = status_q;
		cmd            = '0;
		cmd.out_status = status_q;
		case (state_q)
			hsi_pkg::FSM_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clr_last) begin
					state_d = hsi_pkg::FSM_IDLE;
				end
			end
			hsi_pkg::FSM_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = hsi_pkg::FSM_HASH;
				end
			end
			hsi_pkg::FSM_HASH: begin
				cmd.hash = 1'b1;
				if (sts.sym_ok) begin
					state_d = hsi_pkg::FSM_CHECK;
				end else begin
					status_d = hsi_pkg::ST_NOSYM;
					state_d  = hsi_pkg::FSM_DONE;
				end
			end
			hsi_pkg::FSM_CHECK: begin
				if (sts.match) begin
					cmd.take = 1'b1;
					status_d = hsi_pkg::ST_FOLLOW;
					state_d  = hsi_pkg::FSM_DONE;
				end else if (sts.empty) begin
					cmd.claim = 1'b1;
					cmd.take  = 1'b1;
					status_d  = hsi_pkg::ST_CLAIM;
					state_d   = hsi_pkg::FSM_DONE;
				end else if (sts.wrap) begin
					status_d = hsi_pkg::ST_FULL;
					state_d  = hsi_pkg::FSM_DONE;
				end else begin
					cmd.advance = 1'b1;
					cmd.rd_next = 1'b1;
				end
			end
			hsi_pkg::FSM_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = hsi_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_d = hsi_pkg::FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hsi_pkg::FSM_CLEAR;
			status_q    <= hsi_pkg::ST_FOLLOW;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/hashed_trie_symbol_intern.sv =====
// Channel  Role    Payload                                   Moves when
// sym      sink    char_code[7:0], start_of_name             valid && ready
// res      source  node_index[9:0], name_length[9:0],        valid && ready
//                  status[1:0]
//
// Each request steps through accept, hash, one table read per probe slot, then the
// result load. A character that is not a symbol character skips the probe. The
// single read port of the slot RAM makes every probe wait for its read data.
// After reset a sweep writes all 1024 slots, one per cycle, before sym.ready rises.
// A finished result waits in the output register while the next request is taken;
// the block holds a new result only until that register is free.
module hashed_trie_symbol_intern (
	input  logic      clk,
	input  logic      arst_n,
	hsi_in_if.sink    sym,
	hsi_out_if.source res
);

	hsi_pkg::cmd_t cmd;
	hsi_pkg::sts_t sts;
	logic          in_ready;
	logic          out_valid;

	// The controller sequences each request: hash, probe loop, then the result.
	hsi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sym.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the trie RAM, the probe position and the result register.
	hsi_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.sym_data (sym),
		.res_data (res)
	);

	// Handshake lines are owned here, where the controller's view meets the channels.
	assign sym.ready = in_ready;
	assign res.valid = out_valid;

endmodule
